// File: hw/rtl/double_to_narrow_float_round_defines.svh
// Assertion macros used by the checker file of the double to narrow float rounder.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef DOUBLE_TO_NARROW_FLOAT_ROUND_DEFINES_SVH
`define DOUBLE_TO_NARROW_FLOAT_ROUND_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define DNFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant checked on every rising edge outside reset.
`define DNFR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// File: hw/rtl/dnfr_pkg.sv
// Package for the double to narrow float rounder: codes, constants and stage types.
// No dependencies.
`timescale 1ns / 1ps

package dnfr_pkg;

    localparam int unsigned FMT_W_BITS = 6;
    localparam logic [5:0]  FMT_W_MIN   = 6'd10;
    localparam logic [5:0]  FMT_W_MAX   = 6'd32;
    localparam logic [5:0]  FMT_W_RESET = 6'd16;

    // Double exponent thresholds (biased): below TINY -> zero plus sticky,
    // from HUGE up -> overflow, below SUBN -> subnormal result.
    localparam logic [10:0] DEXP_TINY = 11'd873;   // 1023 - 150
    localparam logic [10:0] DEXP_SUBN = 11'd897;   // 1023 - 126
    localparam logic [10:0] DEXP_HUGE = 11'd1151;  // 1023 + 128
    localparam logic [10:0] DEXP_ONES = 11'h7FF;
    localparam logic [10:0] REBIAS    = 11'd896;   // 1023 - 127

    // Largest finite value, pre-shift: exponent 254, all mantissa and guard bits set
    localparam logic [31:0] MAXFIN_T  = 32'hFEFF_FFFF;
    localparam logic [7:0]  EXP_ONES  = 8'hFF;

    typedef enum logic [2:0] {
        RM_NEAR_EVEN = 3'd0,
        RM_NEAR_AWAY = 3'd1,
        RM_ZERO      = 3'd2,
        RM_UP        = 3'd3,
        RM_DOWN      = 3'd4
    } round_mode_t;

    typedef enum logic {
        CFG_FORMAT_WIDTH = 1'b0,
        CFG_ROUND_MODE   = 1'b1
    } cfg_idx_t;

    // Unpacked word handed from the front end to the rounding stages
    typedef struct packed {
        logic        valid;
        logic        sign;
        logic        special;  // zero, infinity or NaN: spec holds the answer
        logic [31:0] spec;
        logic [31:0] t;        // rebiased 8-bit exponent and 24 mantissa bits, double bits 51..28
        logic        sticky;
    } unp_t;

endpackage

// File: hw/rtl/dnfr_unpack.sv
// Front end of the rounder: classifies the double and aligns subnormal results.
// Two register stages. Uses dnfr_pkg.
`timescale 1ns / 1ps

module dnfr_unpack
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [63:0]        double_bits,
    input  logic               sticky_in,
    output dnfr_pkg::unp_t     unp
);

    // stage A
    logic        a_valid_reg;
    logic        a_sign_reg;
    logic        a_special_reg;
    logic [31:0] a_spec_reg;
    logic        a_tiny_reg;
    logic        a_huge_reg;
    logic        a_subn_reg;
    logic [4:0]  a_off_reg;
    logic [7:0]  a_bexp_reg;
    logic [23:0] a_man_reg;
    logic        a_sticky_reg;

    logic [10:0] dexp;
    logic [51:0] dman;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic [31:0] spec_next;
    logic [10:0] off_full;
    logic [10:0] bexp_full;

    // stage B
    dnfr_pkg::unp_t b_reg;
    dnfr_pkg::unp_t b_next;
    logic [24:0] q;
    logic [24:0] q_sh;
    logic [24:0] lost_mask;

    assign dexp    = double_bits[62:52];
    assign dman    = double_bits[51:0];
    assign is_nan  = (dexp == dnfr_pkg::DEXP_ONES) && (dman != 52'd0);
    assign is_inf  = (dexp == dnfr_pkg::DEXP_ONES) && (dman == 52'd0);
    assign is_zero = (double_bits[62:0] == 63'd0);
    assign off_full  = dnfr_pkg::DEXP_SUBN - dexp;
    assign bexp_full = dexp - dnfr_pkg::REBIAS;

    always_comb
    begin
        spec_next = {double_bits[63], 31'd0};
        if (is_nan)
        begin
            spec_next = {double_bits[63], dnfr_pkg::EXP_ONES, 1'b1, dman[50:29]};
        end
        else if (is_inf)
        begin
            spec_next = {double_bits[63], dnfr_pkg::EXP_ONES, 23'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sign_reg    <= double_bits[63];
        a_special_reg <= is_nan || is_inf || is_zero;
        a_spec_reg    <= spec_next;
        a_tiny_reg    <= dexp < dnfr_pkg::DEXP_TINY;
        a_huge_reg    <= dexp >= dnfr_pkg::DEXP_HUGE;
        a_subn_reg    <= dexp < dnfr_pkg::DEXP_SUBN;
        a_off_reg     <= off_full[4:0];
        a_bexp_reg    <= bexp_full[7:0];
        a_man_reg     <= dman[51:28];
        a_sticky_reg  <= sticky_in || (dman[27:0] != 28'd0);
    end

    // Subnormal: hidden bit in, shift right by the exponent deficit, lost bits to sticky
    assign q         = {1'b1, a_man_reg};
    assign q_sh      = q >> a_off_reg;
    assign lost_mask = (25'd1 << a_off_reg) - 25'd1;

    always_comb
    begin
        b_next.valid   = a_valid_reg;
        b_next.sign    = a_sign_reg;
        b_next.special = a_special_reg;
        b_next.spec    = a_spec_reg;
        priority if (a_tiny_reg)
        begin
            b_next.t      = 32'd0;
            b_next.sticky = 1'b1;
        end
        else if (a_huge_reg)
        begin
            b_next.t      = dnfr_pkg::MAXFIN_T;
            b_next.sticky = 1'b1;
        end
        else if (a_subn_reg)
        begin
            b_next.t      = {8'd0, q_sh[23:0]};
            b_next.sticky = a_sticky_reg || ((q & lost_mask) != 25'd0);
        end
        else
        begin
            b_next.t      = {a_bexp_reg, a_man_reg};
            b_next.sticky = a_sticky_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else
        begin
            b_reg <= b_next;
        end
    end

    assign unp = b_reg;

endmodule

// File: hw/rtl/double_to_narrow_float_round.sv
// Top level of the double to narrow float rounder: config registers and rounding stages.
// Uses dnfr_pkg and dnfr_unpack.
//
//   channel   handshake               payload
//   input     start / busy            double_bits, sticky_in
//   result    result_valid (strobe)   result_bits
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word enters every cycle; result_valid follows start through four register stages
// (decode, subnormal align, round select, add).
// busy never rises: the pipeline has no stall, as results cannot be held off.
// rst_n clears the valid bits and resets format_width to 16 and round_mode to 0.
// cfg_ready is always high; the user must write config only while the pipe is empty (not enforced).
`timescale 1ns / 1ps

module double_to_narrow_float_round
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] double_bits,
    input  logic        sticky_in,
    output logic        result_valid,
    output logic [31:0] result_bits,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);

    logic [5:0] format_width_reg;
    logic [2:0] round_mode_reg;

    dnfr_pkg::unp_t unp;

    logic [5:0]  w_eff;
    logic [5:0]  k_full;
    logic [4:0]  k;
    logic [31:0] low_mask;
    logic        rbit;
    logic        lsb;
    logic        stk;
    logic        up;

    // stage C
    logic        c_valid_reg;
    logic        c_sign_reg;
    logic        c_special_reg;
    logic [31:0] c_spec_reg;
    logic [30:0] c_body_reg;
    logic [30:0] c_inc_reg;

    logic        result_valid_reg;
    logic [31:0] result_bits_reg;
    logic [31:0] result_bits_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_width_reg <= dnfr_pkg::FMT_W_RESET;
            round_mode_reg   <= 3'(dnfr_pkg::RM_NEAR_EVEN);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (dnfr_pkg::cfg_idx_t'(cfg_index))
                dnfr_pkg::CFG_FORMAT_WIDTH: format_width_reg <= cfg_data;
                dnfr_pkg::CFG_ROUND_MODE:   round_mode_reg   <= cfg_data[2:0];
            endcase
        end
    end

    dnfr_unpack u_unpack
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .double_bits (double_bits),
        .sticky_in   (sticky_in),
        .unp         (unp)
    );

    // k = unused low bits of the 32-bit pattern, 0..22
    always_comb
    begin
        priority if (format_width_reg < dnfr_pkg::FMT_W_MIN)
        begin
            w_eff = dnfr_pkg::FMT_W_MIN;
        end
        else if (format_width_reg > dnfr_pkg::FMT_W_MAX)
        begin
            w_eff = dnfr_pkg::FMT_W_MAX;
        end
        else
        begin
            w_eff = format_width_reg;
        end
    end

    assign k_full   = dnfr_pkg::FMT_W_MAX - w_eff;
    assign k        = k_full[4:0];
    assign low_mask = (32'd1 << k) - 32'd1;
    assign rbit     = unp.t[k];
    assign lsb      = unp.t[k + 5'd1];
    assign stk      = unp.sticky || ((unp.t & low_mask) != 32'd0);

    always_comb
    begin
        unique case (round_mode_reg)
            3'(dnfr_pkg::RM_NEAR_EVEN): up = rbit && (lsb || stk);
            3'(dnfr_pkg::RM_NEAR_AWAY): up = rbit;
            3'(dnfr_pkg::RM_UP):        up = !unp.sign && (rbit || stk);
            3'(dnfr_pkg::RM_DOWN):      up = unp.sign && (rbit || stk);
            default:                    up = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= unp.valid;
        end
    end

    // body sits at its final place: T bits above the round bit, low k bits cleared
    always_ff @(posedge clk)
    begin
        c_sign_reg    <= unp.sign;
        c_special_reg <= unp.special;
        c_spec_reg    <= unp.spec & ~low_mask;
        c_body_reg    <= unp.t[31:1] & ~low_mask[30:0];
        c_inc_reg     <= 31'(up) << k;
    end

    assign result_bits_next = c_special_reg ? c_spec_reg
                                            : {c_sign_reg, c_body_reg + c_inc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_bits_reg <= result_bits_next;
    end

    assign result_valid = result_valid_reg;
    assign result_bits  = result_bits_reg;

endmodule

// File: hw/rtl/dnfr_checker.sv
// Port-level checks for the double to narrow float rounder, bound to its top level.
// Uses the macros in double_to_narrow_float_round_defines.svh.
`timescale 1ns / 1ps
`include "double_to_narrow_float_round_defines.svh"

module dnfr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [63:0] double_bits,
    input logic        result_valid,
    input logic [31:0] result_bits
);

    // every accepted word comes out as a result
    `DNFR_ASSERT_IMP(a_latency, start && !busy, ##4 result_valid, "result missing after accept")
    `DNFR_ASSERT_IMP(a_no_spurious, result_valid, $past(start && !busy, 4), "result without word")
    // sign survives every path, specials included
    `DNFR_ASSERT_IMP(a_sign, result_valid, result_bits[31] == $past(double_bits[63], 4), "sign lost")
    `DNFR_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule

bind double_to_narrow_float_round dnfr_checker u_dnfr_checker (.*);
